>>> sv/u8v_pkg.sv
// Package: shared types and constants for the UTF-8 string validator.
package u8v_pkg;

    localparam int unsigned LEN_W = 16;
    localparam int unsigned CNT_W = 17;
    localparam int unsigned ACC_W = 21;

    localparam logic [CNT_W-1:0] CNT_SAT     = 17'h10000;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'd1024;

    localparam logic [ACC_W-1:0] MIN_2B    = 21'h80;
    localparam logic [ACC_W-1:0] MIN_3B    = 21'h800;
    localparam logic [ACC_W-1:0] MIN_4B    = 21'h10000;
    localparam logic [ACC_W-1:0] MAX_CP    = 21'h10FFFF;
    localparam logic [ACC_W-1:0] SURR_LO   = 21'hD800;
    localparam logic [ACC_W-1:0] SURR_HI   = 21'hDFFF;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_2B   = 2'd1,
        CLS_3B   = 2'd2,
        CLS_4B   = 2'd3
    } t_seq_cls;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] byte_count;
    } t_result;

    typedef struct packed {
        logic [1:0]       pend;
        logic [ACC_W-1:0] acc;
        t_seq_cls         cls;
        logic             err;
        logic [CNT_W-1:0] cnt;
    } t_state;

    localparam t_state STATE_CLR = '{pend: 2'd0, acc: '0, cls: CLS_NONE, err: 1'b0, cnt: '0};

endpackage

>>> sv/u8v_ifs.sv
// Interfaces: byte item, result and configuration write channels.
interface u8v_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
    modport source (output valid, data_byte, has_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface u8v_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [16:0] byte_count;
    modport source (output valid, accepted, byte_count, input ready);
    modport sink   (input valid, accepted, byte_count, output ready);
endinterface

interface u8v_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/utf8_string_validator.sv
// Top level: strict UTF-8 string validator with length limit.
// Takes one byte per cycle and keeps up with back-to-back transactions: each
// item is registered, decoded combinationally against the running string state,
// and the verdict for the item marked last lands in an output register, so an
// item can be accepted every cycle while the output is taken. A last item passes
// the input register, then the result register. The only stall comes from a
// held result register when the downstream side is not ready. The length limit
// register is written through the configuration channel, which is always ready.
module utf8_string_validator
    import u8v_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8v_item_if.sink     i_item,
    u8v_result_if.source o_result,
    u8v_cfg_if.sink      i_cfg
);

    logic             stg_valid;
    t_item            stg_item;
    logic             out_free;
    logic             advance;
    t_state           r_state;
    t_state           n_state;
    t_result          n_result;
    t_result          r_result;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_max_len;

    assign out_free = !r_out_valid || o_result.ready;
    assign advance  = stg_valid && (!stg_item.last_byte || out_free);

    u8v_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_valid   (stg_valid),
        .o_item    (stg_item)
    );

    u8v_decode u_dec (
        .i_state   (r_state),
        .i_item    (stg_item),
        .i_max_len (r_max_len),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && stg_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && stg_item.last_byte) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.accepted   = r_result.accepted;
    assign o_result.byte_count = r_result.byte_count;

endmodule

>>> sv/u8v_in_stage.sv
// Input register stage: captures one byte item per transaction.
module u8v_in_stage
    import u8v_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8v_item_if.sink    i_item,
    input  logic        i_advance,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;

    assign i_item.ready = !r_valid || i_advance;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_item <= '{data_byte: i_item.data_byte, has_byte: i_item.has_byte,
                        last_byte: i_item.last_byte};
        end
    end

endmodule

>>> sv/u8v_decode.sv
// Per-byte decode step: next string state and verdict for one item.
module u8v_decode
    import u8v_pkg::*;
(
    input  t_state           i_state,
    input  t_item            i_item,
    input  logic [LEN_W-1:0] i_max_len,
    output t_state           o_state,
    output t_result          o_result
);

    t_state           s;
    logic [7:0]       c;
    logic [ACC_W-1:0] acc_sh;
    logic [ACC_W-1:0] smallest;

    assign c      = i_item.data_byte;
    assign acc_sh = {i_state.acc[ACC_W-7:0], c[5:0]};

    always_comb begin
        case (i_state.cls)
            CLS_2B:  smallest = MIN_2B;
            CLS_3B:  smallest = MIN_3B;
            default: smallest = MIN_4B;
        endcase
    end

    always_comb begin
        s = i_state;
        if (i_item.has_byte) begin
            if (s.cnt != CNT_SAT) begin
                s.cnt = s.cnt + 1'b1;
            end
            if (!i_state.err) begin
                if (i_state.pend == 2'd0) begin
                    if (c == 8'h00) begin
                        s.err = 1'b1;
                    end else if (c inside {[8'h01:8'h7F]}) begin
                        s.err = 1'b0;
                    end else if (c inside {[8'hC0:8'hDF]}) begin
                        s.pend = 2'd1;
                        s.cls  = CLS_2B;
                        s.acc  = {16'd0, c[4:0]};
                    end else if (c inside {[8'hE0:8'hEF]}) begin
                        s.pend = 2'd2;
                        s.cls  = CLS_3B;
                        s.acc  = {17'd0, c[3:0]};
                    end else if (c inside {[8'hF0:8'hF7]}) begin
                        s.pend = 2'd3;
                        s.cls  = CLS_4B;
                        s.acc  = {18'd0, c[2:0]};
                    end else begin
                        s.err = 1'b1;
                    end
                end else if (c[7:6] != 2'b10) begin
                    s.err = 1'b1;
                end else begin
                    s.acc  = acc_sh;
                    s.pend = i_state.pend - 2'd1;
                    if (i_state.pend == 2'd1) begin
                        if (acc_sh < smallest || acc_sh > MAX_CP ||
                            (acc_sh >= SURR_LO && acc_sh <= SURR_HI)) begin
                            s.err = 1'b1;
                        end
                        s.acc = '0;
                        s.cls = CLS_NONE;
                    end
                end
            end
        end
        o_result.accepted   = !s.err && (s.pend == 2'd0) && (s.cnt <= {1'b0, i_max_len});
        o_result.byte_count = s.cnt;
        o_state = i_item.last_byte ? STATE_CLR : s;
    end

endmodule
